// ===== hdl/assc_pkg.sv =====
// Shared types and constants of the adaptive step size controller.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package assc_pkg;

	// Field widths
	localparam int TIME_W    = 48;
	localparam int NORM_W    = 32;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 1;
	localparam int MULT_W    = 18;

	// Datapath widths: 81*tol, 25*norm, 100*norm, 625*norm, 8*100*norm
	localparam int ALU_W   = 50;
	localparam int A_W     = 39;
	localparam int N25_W   = 37;
	localparam int N625_W  = 42;
	localparam int DIV_W   = 42;
	localparam int Q_W     = 35;
	localparam int CNT_W   = 6;
	localparam int DIV_STEPS  = 35;
	localparam int SQRT_STEPS = 18;

	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_STEP = 1'd1;

	localparam logic CMD_ADVANCE = 1'b0;
	localparam logic CMD_ADJUST  = 1'b1;

	localparam logic [NORM_W-1:0] TOLERANCE_RST = 32'd66;
	localparam logic [TIME_W-1:0] INIT_STEP_RST = 48'd16777;
	localparam logic [TIME_W-1:0] TIME_MAX      = 48'hFFFF_FFFF_FFFF;

	// Multiplier codes, Q2.16
	localparam logic [MULT_W-1:0] MULT_HALF      = 18'd32768;
	localparam logic [MULT_W-1:0] MULT_ONE       = 18'd65536;
	localparam logic [MULT_W-1:0] MULT_CEIL_HIGH = 18'd163840;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK     = 2'd0,
		STATUS_LAND   = 2'd1,
		STATUS_RECALC = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADV_SUM,
		ST_ADV_TOT,
		ST_ADV_CMP,
		ST_ADV_END,
		ST_ADJ_PRE,
		ST_ADJ_FLOOR,
		ST_ADJ_CEIL,
		ST_DIV,
		ST_SQRT,
		ST_MUL,
		ST_SUM,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/assc_ifs.sv =====
// Channel interfaces: command input, result output and configuration write.
// Depends on assc_pkg for field widths.
`default_nettype none

interface assc_req_if;
	logic                           valid;
	logic                           ready;
	logic                           cmd;
	logic [assc_pkg::NORM_W-1:0]    error_norm;
	logic [assc_pkg::TIME_W-1:0]    next_output_time;

	modport source (output valid, cmd, error_norm, next_output_time, input ready);
	modport sink   (input valid, cmd, error_norm, next_output_time, output ready);
endinterface

interface assc_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [assc_pkg::STATUS_W-1:0]  step_status;
	logic [assc_pkg::TIME_W-1:0]    current_step;
	logic [assc_pkg::TIME_W-1:0]    proposed_step;
	logic [assc_pkg::TIME_W-1:0]    current_time;

	modport source (output valid, step_status, current_step, proposed_step, current_time,
		input ready);
	modport sink   (input valid, step_status, current_step, proposed_step, current_time,
		output ready);
endinterface

interface assc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [assc_pkg::CFG_IDX_W-1:0] index;
	logic [assc_pkg::TIME_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/assc_csub.sv =====
// Shared compare-and-subtract unit used for the sequencer's compare, divide and root steps.
// Depends on assc_pkg for the unit width.
`default_nettype none

module assc_csub (
	input  wire logic [assc_pkg::ALU_W-1:0] x,
	input  wire logic [assc_pkg::ALU_W-1:0] y,
	output logic      [assc_pkg::ALU_W-1:0] diff,
	output logic                            ge
);

	logic [assc_pkg::ALU_W:0] wide;

	always_comb begin
		wide = {1'b0, x} - {1'b0, y};
		diff = wide[assc_pkg::ALU_W-1:0];
		ge   = ~wide[assc_pkg::ALU_W];
	end

endmodule

`default_nettype wire

// ===== hdl/assc_scale.sv =====
// Step scaler: step * m / 2^16 as two registered partial products, saturated.
// Depends on assc_pkg for widths and the saturation limit.
`default_nettype none

module assc_scale (
	input  wire logic                             clk,
	input  wire logic                             load,
	input  wire logic [assc_pkg::TIME_W-1:0]      step,
	input  wire logic [assc_pkg::MULT_W-1:0]      mult,
	output logic      [assc_pkg::TIME_W-1:0]      product
);

	localparam int HI_W = assc_pkg::TIME_W - 16 + assc_pkg::MULT_W;
	localparam int LO_W = 16 + assc_pkg::MULT_W;

	logic [HI_W-1:0] hi_prod_q;
	logic [LO_W-1:0] lo_prod_q;
	logic [HI_W:0]   sum;

	always_ff @(posedge clk) begin
		if (load) begin
			hi_prod_q <= HI_W'(step[assc_pkg::TIME_W-1:16]) * HI_W'(mult);
			lo_prod_q <= LO_W'(step[15:0]) * LO_W'(mult);
		end
	end

	always_comb begin
		sum = {1'b0, hi_prod_q} + (HI_W + 1)'(lo_prod_q[LO_W-1:16]);
		if (sum[HI_W:assc_pkg::TIME_W] != '0) begin
			product = assc_pkg::TIME_MAX;
		end else begin
			product = sum[assc_pkg::TIME_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/adaptive_step_size_controller.sv =====
// Top level of the adaptive step size controller: sequencer and state registers.
// Depends on assc_pkg, assc_ifs, assc_csub and assc_scale.
//
//   channel | direction | payload
//   --------+-----------+------------------------------------------------------
//   req     | in        | cmd, error_norm (Q16.16), next_output_time (Q24.24)
//   rsp     | out       | step_status, current_step, proposed_step, current_time
//   cfg     | in        | index (0 tolerance, 1 initial_step), data
//
// An advance transaction runs ST_ADV_SUM, ST_ADV_TOT, ST_ADV_CMP and ST_ADV_END:
// two adds on one adder, two compares on the shared compare-and-subtract unit.
// An adjust transaction at the floor or ceiling skips divide and root, else runs
// 35 restoring divide and 18 square root steps, one per cycle on that unit.
// req.ready is high only while the sequencer is idle; a result waits in the
// output register and the next transaction is accepted meanwhile, but finishing
// it holds until the previous result is taken. Reset restores all step state.
`default_nettype none

module adaptive_step_size_controller (
	input  wire logic   clk,
	input  wire logic   arst_n,
	assc_req_if.sink    req,
	assc_rsp_if.source  rsp,
	assc_cfg_if.sink    cfg
);

	localparam int TW = assc_pkg::TIME_W;
	localparam int AW = assc_pkg::ALU_W;

	assc_pkg::state_t  state_q, state_d;
	assc_pkg::status_t status_q;

	// architectural state
	logic [assc_pkg::NORM_W-1:0] tol_q;
	logic [TW-1:0]               start_q;
	logic [TW-1:0]               step_now_q;
	logic [TW-1:0]               proposed_q;
	logic [TW-1:0]               saved_q;
	logic                        low_q;

	// captured transaction
	logic [assc_pkg::NORM_W-1:0] norm_q;
	logic [TW-1:0]               next_out_q;

	// working registers
	logic [TW:0]                 end_q;
	logic [TW+1:0]               tot_q;
	logic                        land_q;
	logic [assc_pkg::A_W-1:0]    a_q;
	logic [assc_pkg::N25_W-1:0]  n25_q;
	logic [assc_pkg::A_W-1:0]    b_q;
	logic [assc_pkg::N625_W-1:0] n625_q;
	logic [assc_pkg::DIV_W-1:0]  rem_q;
	logic [assc_pkg::DIV_W-1:0]  den_q;
	logic [assc_pkg::Q_W-1:0]    quo_q;
	logic [assc_pkg::CNT_W-1:0]  cnt_q;
	logic [assc_pkg::Q_W-1:0]    sq_v_q;
	logic [assc_pkg::Q_W-1:0]    sq_root_q;
	logic [assc_pkg::Q_W-1:0]    sq_bit_q;
	logic [assc_pkg::MULT_W-1:0] m_q;

	// output register
	logic                        out_valid_q;
	assc_pkg::status_t           out_status_q;
	logic [TW-1:0]               out_step_q;
	logic [TW-1:0]               out_prop_q;
	logic [TW-1:0]               out_time_q;

	// combinational
	logic [AW-1:0]               alu_x, alu_y, alu_diff;
	logic                        alu_ge;
	logic [TW+1:0]               add_a, add_b, add_sum;
	logic                        in_ready, scale_load, out_load;
	logic [TW-1:0]               scale_prod;
	logic [assc_pkg::MULT_W-1:0] ceil_m;
	logic                        norm_nz, below_floor, keep_saved;
	logic [assc_pkg::DIV_W-1:0]  rem_next;
	logic [assc_pkg::Q_W-1:0]    quo_next;
	logic [assc_pkg::Q_W-1:0]    root_next;
	logic [assc_pkg::Q_W-1:0]    v_next;
	logic [assc_pkg::MULT_W-1:0] root_clamped;
	logic                        cfg_wr;

	assc_csub u_csub (
		.x    (alu_x),
		.y    (alu_y),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	assc_scale u_scale (
		.clk     (clk),
		.load    (scale_load),
		.step    (step_now_q),
		.mult    (m_q),
		.product (scale_prod)
	);

	assign ceil_m      = low_q ? assc_pkg::MULT_ONE : assc_pkg::MULT_CEIL_HIGH;
	assign norm_nz     = (norm_q != '0);
	// valid in ST_ADJ_FLOOR: 0.81*tol/norm below 0.25 puts the multiplier under 0.5
	assign below_floor = norm_nz && !alu_ge;
	assign keep_saved  = (status_q == assc_pkg::STATUS_LAND) && (m_q > assc_pkg::MULT_ONE);
	assign add_sum     = add_a + add_b;
	assign cfg_wr      = cfg.valid && cfg.ready;

	// divide step: double the partial remainder, subtract the scaled divisor if it fits
	assign rem_next = alu_ge ? alu_diff[assc_pkg::DIV_W-1:0]
	                         : {rem_q[assc_pkg::DIV_W-2:0], 1'b0};
	assign quo_next = {quo_q[assc_pkg::Q_W-2:0], alu_ge};

	// square root step, one result bit per cycle
	assign root_next = alu_ge ? ((sq_root_q >> 1) | sq_bit_q) : (sq_root_q >> 1);
	assign v_next    = alu_ge ? alu_diff[assc_pkg::Q_W-1:0] : sq_v_q;
	assign root_clamped = (root_next > assc_pkg::Q_W'(ceil_m))
	                    ? ceil_m : root_next[assc_pkg::MULT_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			assc_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = (req.cmd == assc_pkg::CMD_ADJUST) ? assc_pkg::ST_ADJ_PRE
					                                            : assc_pkg::ST_ADV_SUM;
				end
			end
			assc_pkg::ST_ADV_SUM:   state_d = assc_pkg::ST_ADV_TOT;
			assc_pkg::ST_ADV_TOT:   state_d = assc_pkg::ST_ADV_CMP;
			assc_pkg::ST_ADV_CMP:   state_d = assc_pkg::ST_ADV_END;
			assc_pkg::ST_ADV_END:   state_d = assc_pkg::ST_DONE;
			assc_pkg::ST_ADJ_PRE:   state_d = assc_pkg::ST_ADJ_FLOOR;
			assc_pkg::ST_ADJ_FLOOR: begin
				if (below_floor || !norm_nz) begin
					state_d = assc_pkg::ST_MUL;
				end else begin
					state_d = assc_pkg::ST_ADJ_CEIL;
				end
			end
			assc_pkg::ST_ADJ_CEIL: begin
				state_d = alu_ge ? assc_pkg::ST_MUL : assc_pkg::ST_DIV;
			end
			assc_pkg::ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = assc_pkg::ST_SQRT;
				end
			end
			assc_pkg::ST_SQRT: begin
				if (cnt_q == '0) begin
					state_d = assc_pkg::ST_MUL;
				end
			end
			assc_pkg::ST_MUL: begin
				state_d = keep_saved ? assc_pkg::ST_DONE : assc_pkg::ST_SUM;
			end
			assc_pkg::ST_SUM:       state_d = assc_pkg::ST_DONE;
			assc_pkg::ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = assc_pkg::ST_IDLE;
				end
			end
			default:                state_d = assc_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer: handshakes and operand selection
	always_comb begin
		in_ready   = 1'b0;
		scale_load = 1'b0;
		out_load   = 1'b0;
		alu_x      = '0;
		alu_y      = '0;
		add_a      = '0;
		add_b      = '0;
		case (state_q)
			assc_pkg::ST_IDLE:    in_ready = 1'b1;
			assc_pkg::ST_ADV_SUM: begin
				add_a = (TW + 2)'(start_q);
				add_b = (TW + 2)'(step_now_q);
			end
			assc_pkg::ST_ADV_TOT: begin
				add_a = (TW + 2)'(end_q);
				add_b = (TW + 2)'(proposed_q);
			end
			assc_pkg::ST_ADV_CMP: begin
				alu_x = AW'(next_out_q);
				alu_y = AW'(tot_q);
			end
			assc_pkg::ST_ADV_END: begin
				alu_x = AW'(next_out_q);
				alu_y = AW'(end_q);
			end
			assc_pkg::ST_ADJ_FLOOR: begin
				alu_x = AW'(a_q);
				alu_y = AW'(n25_q);
			end
			assc_pkg::ST_ADJ_CEIL: begin
				alu_x = AW'(a_q);
				alu_y = low_q ? AW'(b_q) : AW'(n625_q);
			end
			assc_pkg::ST_DIV: begin
				alu_x = AW'({rem_q, 1'b0});
				alu_y = AW'(den_q);
			end
			assc_pkg::ST_SQRT: begin
				alu_x = AW'(sq_v_q);
				alu_y = AW'(sq_root_q | sq_bit_q);
			end
			assc_pkg::ST_MUL:     scale_load = !keep_saved;
			assc_pkg::ST_DONE:    out_load = !out_valid_q || rsp.ready;
			default: begin
			end
		endcase
	end

	assign req.ready = in_ready;
	assign cfg.ready = 1'b1;

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= assc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// architectural step state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q      <= assc_pkg::TOLERANCE_RST;
			start_q    <= '0;
			step_now_q <= assc_pkg::INIT_STEP_RST;
			proposed_q <= assc_pkg::INIT_STEP_RST;
			saved_q    <= '0;
			low_q      <= 1'b0;
			status_q   <= assc_pkg::STATUS_OK;
		end else if (cfg_wr) begin
			// the user must write only while idle; the block itself does not enforce it
			if (cfg.index == assc_pkg::REG_TOLERANCE) begin
				tol_q <= cfg.data[assc_pkg::NORM_W-1:0];
			end else begin
				step_now_q <= cfg.data;
				proposed_q <= cfg.data;
			end
		end else begin
			case (state_q)
				assc_pkg::ST_ADV_END: begin
					// land on the output time if the proposed step would overshoot it
					if (land_q) begin
						saved_q    <= proposed_q;
						step_now_q <= alu_ge ? alu_diff[TW-1:0] : '0;
						status_q   <= assc_pkg::STATUS_LAND;
						low_q      <= 1'b1;
					end else begin
						step_now_q <= proposed_q;
						status_q   <= assc_pkg::STATUS_OK;
						low_q      <= 1'b0;
					end
					start_q <= end_q[TW] ? assc_pkg::TIME_MAX : end_q[TW-1:0];
				end
				assc_pkg::ST_ADJ_FLOOR: begin
					if (below_floor) begin
						step_now_q <= step_now_q >> 1;
						low_q      <= 1'b1;
						status_q   <= assc_pkg::STATUS_RECALC;
					end else if (status_q == assc_pkg::STATUS_RECALC) begin
						status_q <= assc_pkg::STATUS_OK;
					end
				end
				assc_pkg::ST_MUL: begin
					if (keep_saved) begin
						proposed_q <= saved_q;
					end
				end
				assc_pkg::ST_SUM: proposed_q <= scale_prod;
				default: begin
				end
			endcase
		end
	end

	// working registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			assc_pkg::ST_IDLE: begin
				norm_q     <= req.error_norm;
				next_out_q <= req.next_output_time;
			end
			assc_pkg::ST_ADV_SUM: end_q <= add_sum[TW:0];
			assc_pkg::ST_ADV_TOT: tot_q <= add_sum;
			assc_pkg::ST_ADV_CMP: land_q <= !alu_ge;
			assc_pkg::ST_ADJ_PRE: begin
				// 81*tol and 25*norm by shift and add
				a_q   <= assc_pkg::A_W'({tol_q, 6'b0}) + assc_pkg::A_W'({tol_q, 4'b0})
				       + assc_pkg::A_W'(tol_q);
				n25_q <= assc_pkg::N25_W'({norm_q, 4'b0}) + assc_pkg::N25_W'({norm_q, 3'b0})
				       + assc_pkg::N25_W'(norm_q);
			end
			assc_pkg::ST_ADJ_FLOOR: begin
				b_q    <= {n25_q, 2'b0};
				n625_q <= assc_pkg::N625_W'({n25_q, 4'b0}) + assc_pkg::N625_W'({n25_q, 3'b0})
				        + assc_pkg::N625_W'(n25_q);
				if (below_floor) begin
					m_q <= assc_pkg::MULT_HALF;
				end else if (!norm_nz) begin
					m_q <= ceil_m;
				end
			end
			assc_pkg::ST_ADJ_CEIL: begin
				if (alu_ge) begin
					m_q <= ceil_m;
				end
				// a*2^32/b as a*2^35/(8b) keeps the remainder below the divisor
				rem_q <= assc_pkg::DIV_W'(a_q);
				den_q <= {b_q, 3'b0};
				quo_q <= '0;
				cnt_q <= assc_pkg::CNT_W'(assc_pkg::DIV_STEPS - 1);
			end
			assc_pkg::ST_DIV: begin
				rem_q <= rem_next;
				quo_q <= quo_next;
				if (cnt_q == '0) begin
					sq_v_q    <= quo_next;
					sq_root_q <= '0;
					sq_bit_q  <= {1'b1, {(assc_pkg::Q_W - 1){1'b0}}};
					cnt_q     <= assc_pkg::CNT_W'(assc_pkg::SQRT_STEPS - 1);
				end else begin
					cnt_q <= cnt_q - assc_pkg::CNT_W'(1);
				end
			end
			assc_pkg::ST_SQRT: begin
				sq_v_q    <= v_next;
				sq_root_q <= root_next;
				sq_bit_q  <= sq_bit_q >> 2;
				cnt_q     <= cnt_q - assc_pkg::CNT_W'(1);
				if (cnt_q == '0) begin
					m_q <= root_clamped;
				end
			end
			default: begin
			end
		endcase
	end

	// output register: hold the result until it is taken on rsp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			out_step_q   <= step_now_q;
			out_prop_q   <= proposed_q;
			out_time_q   <= start_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.step_status   = out_status_q;
	assign rsp.current_step  = out_step_q;
	assign rsp.proposed_step = out_prop_q;
	assign rsp.current_time  = out_time_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("accepted a transaction while busy");

	a_sqrt_bit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == assc_pkg::ST_SQRT) |-> $onehot(sq_bit_q))
		else $error("square root bit lost its single set bit");

	a_mult_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == assc_pkg::ST_MUL) |-> (m_q >= assc_pkg::MULT_HALF && m_q <= ceil_m))
		else $error("multiplier outside floor and ceiling");

	a_recalc_low_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q == assc_pkg::STATUS_RECALC) |-> low_q)
		else $error("recalculation status without low ceiling");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == assc_pkg::ST_DONE && out_valid_q && !rsp.ready) |=>
		(state_q == assc_pkg::ST_DONE))
		else $error("finished transaction overwrote a pending result");
`endif

endmodule

`default_nettype wire
